// File: design/rigid_constraint_force_to_displacement_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the constraint force block
// Shared property wrappers used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef RIGID_CONSTRAINT_FORCE_TO_DISPLACEMENT_MACROS_SVH
`define RIGID_CONSTRAINT_FORCE_TO_DISPLACEMENT_MACROS_SVH

// implication checked every cycle outside reset
`define RCF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define RCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg
// Types and constants shared by the constraint force block.
// ----------------------------------------------------------------------------
package rcf_pkg;

  localparam int NUM_BODIES_DEF = 64;
  localparam int BODY_W         = 6;
  localparam int DATA_W         = 32;
  localparam int ACC_W          = 48;
  localparam int CFG_IDX_W      = 3;
  localparam int IN_TDATA_W     = 232;
  localparam int OUT_TDATA_W    = 200;

  localparam logic [CFG_IDX_W-1:0] REG_LIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_XX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_XY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_XZ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YZ  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZZ  = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic       load;       // capture request
    logic       acc_clr;    // clear pending sum
    logic       rd;         // read store word
    logic       inc;        // add increment to the read word and write back
    logic       mul;        // accumulate one compliance half product
    logic       half;       // 0 low 24 bits of the store word, 1 high 24 bits
    logic       fin;        // round and save one output
    logic [2:0] comp;       // component 0..5
    logic [1:0] term;       // dot term 0..2
    logic       out_load;   // present result
  } ctl_t;

  typedef struct packed {
    logic in_range;
    logic out_busy;
    logic clr_busy;
  } sts_t;

endpackage

// File: design/rcf_ctrl.sv
// ----------------------------------------------------------------------------
// rcf_ctrl
// Sequencer for update and displacement phases.
// ----------------------------------------------------------------------------
module rcf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          in_apply,
  input  rcf_pkg::sts_t sts,
  output logic          in_ready,
  output rcf_pkg::ctl_t ctl
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CHK  = 6'b000010,
    S_RD   = 6'b000100,
    S_UPD  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] comp_r, comp_nxt;
  logic [1:0] term_r, term_nxt;
  logic       half_r, half_nxt;
  logic [1:0] nterm;

  assign nterm = (comp_r < 3'd3) ? 2'd0 : 2'd2;

  always_comb begin
    state_nxt = state_r;
    comp_nxt  = comp_r;
    term_nxt  = term_r;
    half_nxt  = half_r;
    ctl       = '0;
    ctl.comp  = comp_r;
    ctl.term  = term_r;
    ctl.half  = half_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = !sts.clr_busy;
        if (in_fire) begin
          ctl.load = 1'b1;
          if (in_apply) state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        comp_nxt = 3'd0;
        state_nxt = sts.in_range ? S_RD : S_IDLE;
      end
      S_RD: begin
        ctl.rd = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        ctl.inc = 1'b1;
        if (comp_r == 3'd5) begin
          comp_nxt  = 3'd0;
          term_nxt  = 2'd0;
          half_nxt  = 1'b0;
          ctl.acc_clr = 1'b1;
          state_nxt = S_MUL;
        end else begin
          comp_nxt  = comp_r + 3'd1;
          state_nxt = S_RD;
        end
      end
      S_MUL: begin
        ctl.mul = 1'b1;
        if (!half_r) begin
          half_nxt = 1'b1;
        end else begin
          half_nxt = 1'b0;
          if (term_r == nterm) begin
            ctl.fin = 1'b1;
            term_nxt = 2'd0;
            if (comp_r == 3'd5) state_nxt = S_OUT;
            else comp_nxt = comp_r + 3'd1;
          end else begin
            term_nxt = term_r + 2'd1;
          end
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      comp_r  <= 3'd0;
      term_r  <= 2'd0;
      half_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      comp_r  <= comp_nxt;
      term_r  <= term_nxt;
      half_r  <= half_nxt;
    end
  end

  `include "rigid_constraint_force_to_displacement_macros.svh"
  `RCF_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE)
  `RCF_ASSERT_IMPL(a_comp_rng, clk, rst_n, state_r != S_IDLE, comp_r <= 3'd5)
  `RCF_ASSERT_NEXT(a_out_idle, clk, rst_n, ctl.out_load, state_r == S_IDLE)
  `RCF_ASSERT_IMPL(a_fin_half, clk, rst_n, ctl.fin, half_r)

endmodule

// File: design/rcf_datapath.sv
// ----------------------------------------------------------------------------
// rcf_datapath
// Force store, increment and displacement multipliers and output register.
// ----------------------------------------------------------------------------
module rcf_datapath #(
  parameter int NUM_BODIES = rcf_pkg::NUM_BODIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rcf_pkg::ctl_t                    ctl,
  output rcf_pkg::sts_t                    sts,
  input  logic                             cfg_we,
  input  logic [rcf_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [rcf_pkg::DATA_W-1:0]       cfg_wdata,
  input  logic [rcf_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rcf_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int DEPTH = NUM_BODIES * 6;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = rcf_pkg::BODY_W;

  logic signed [31:0] creg_r [7];
  logic [BW-1:0]      body_r;
  logic signed [31:0] dir_r [6];
  logic signed [31:0] step_r;

  logic [47:0] mem [DEPTH];
  logic [AW-1:0] clr_addr_r;
  logic          clr_busy_r;
  logic [47:0] rd_r;
  logic signed [47:0] f_r [6];
  logic [AW-1:0] addr;

  logic signed [80:0] acc_r;
  logic signed [31:0] res_r [6];
  logic signed [63:0] prod;
  logic signed [63:0] incr;
  logic signed [48:0] sum;
  logic signed [47:0] sat48;
  logic signed [47:0] fop;
  logic signed [31:0] cop;
  logic signed [24:0] mop;
  logic signed [56:0] mprod;
  logic signed [80:0] acc_new, rnd;
  logic signed [31:0] sat32;
  logic               out_v_r;
  logic [rcf_pkg::OUT_TDATA_W-1:0] out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) creg_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        rcf_pkg::REG_LIN: creg_r[0] <= cfg_wdata;
        rcf_pkg::REG_XX:  creg_r[1] <= cfg_wdata;
        rcf_pkg::REG_XY:  creg_r[2] <= cfg_wdata;
        rcf_pkg::REG_XZ:  creg_r[3] <= cfg_wdata;
        rcf_pkg::REG_YY:  creg_r[4] <= cfg_wdata;
        rcf_pkg::REG_YZ:  creg_r[5] <= cfg_wdata;
        rcf_pkg::REG_ZZ:  creg_r[6] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      body_r <= in_tdata[6:1];
      for (int k = 0; k < 6; k++) dir_r[k] <= in_tdata[7+32*k +: 32];
      step_r <= in_tdata[230:199];
    end
  end

  assign sts.in_range = (NUM_BODIES >= (1 << BW)) ||
                        ({1'b0, body_r} < (BW+1)'(NUM_BODIES));
  assign sts.out_busy = out_v_r && !out_tready;
  assign sts.clr_busy = clr_busy_r;

  assign addr = AW'(body_r) * AW'(6) + AW'(ctl.comp);

  // increment path: product, round, add to the read word, saturate
  assign prod  = dir_r[ctl.comp] * step_r;
  assign incr  = (prod + 64'sd536870912) >>> 30;
  assign sum   = 49'(signed'(rd_r)) + 49'(incr);
  assign sat48 = (sum > 49'sh7FFFFFFFFFFF) ? 48'sh7FFFFFFFFFFF :
                 (sum < -49'sh800000000000) ? -48'sh800000000000 : sum[47:0];

  // zero the store one word per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH-1)) clr_busy_r <= 1'b0;
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) rd_r <= mem[addr];
    if (clr_busy_r) mem[clr_addr_r] <= '0;
    else if (ctl.inc) mem[addr] <= sat48;
    if (ctl.inc) f_r[ctl.comp] <= sat48;
  end

  // displacement path: one half product per cycle into a wide sum
  always_comb begin
    fop = f_r[ctl.comp];
    cop = creg_r[0];
    if (ctl.comp >= 3'd3) begin
      fop = f_r[3 + 32'(ctl.term)];
      case (ctl.comp)
        3'd3: cop = (ctl.term == 2'd0) ? creg_r[1] :
                    (ctl.term == 2'd1) ? creg_r[2] : creg_r[3];
        3'd4: cop = (ctl.term == 2'd0) ? creg_r[2] :
                    (ctl.term == 2'd1) ? creg_r[4] : creg_r[5];
        default: cop = (ctl.term == 2'd0) ? creg_r[3] :
                       (ctl.term == 2'd1) ? creg_r[5] : creg_r[6];
      endcase
    end
  end

  assign mop     = ctl.half ? {fop[47], fop[47:24]} : {1'b0, fop[23:0]};
  assign mprod   = mop * cop;
  assign acc_new = acc_r + (ctl.half ? (81'(mprod) <<< 24) : 81'(mprod));
  assign rnd     = (acc_new + 81'sh80000000) >>> 32;
  assign sat32   = (rnd > 81'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                   (rnd < -81'sh80000000) ? -32'sh80000000 : rnd[31:0];

  always_ff @(posedge clk) begin
    if (ctl.acc_clr || ctl.fin) acc_r <= '0;
    else if (ctl.mul) acc_r <= acc_new;
    if (ctl.fin) res_r[ctl.comp] <= sat32;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (ctl.out_load) out_v_r <= 1'b1;
    else if (out_tready) out_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load)
      out_d_r <= {2'b0, res_r[5], res_r[4], res_r[3], res_r[2], res_r[1], res_r[0], body_r};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  `include "rigid_constraint_force_to_displacement_macros.svh"
  `RCF_ASSERT_IMPL(a_no_over, clk, rst_n, ctl.out_load, !sts.out_busy)
  `RCF_ASSERT_NEXT(a_out_set, clk, rst_n, ctl.out_load, out_v_r)
  `RCF_ASSERT_IMPL(a_inc_rng, clk, rst_n, ctl.inc, sts.in_range)
  `RCF_ASSERT_IMPL(a_clr_no_inc, clk, rst_n, clr_busy_r, !ctl.inc)

endmodule

// File: design/rigid_constraint_force_to_displacement.sv
// Per applied request: a range check, the six read and write-back updates,
// the twelve compliance terms at two half products each, and an output load
// that waits while the previous result is still held by out_tready.
// A new request is taken only when idle; those without apply_update or with
// an out-of-range body skip the update. Reset: synchronous active-low; input
// held off while the force store is zeroed.
// ----------------------------------------------------------------------------
// rigid_constraint_force_to_displacement
// Accumulate constraint force per body and report compliant displacement.
// ----------------------------------------------------------------------------
module rigid_constraint_force_to_displacement #(
  parameter int NUM_BODIES = rcf_pkg::NUM_BODIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rcf_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [rcf_pkg::DATA_W-1:0]       cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // apply_update, body_index, dir_lin_x..z, dir_ang_x..z, force_step
  input  logic [rcf_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_body, disp_lin_x..z, disp_ang_x..z
  output logic [rcf_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  rcf_pkg::ctl_t ctl;
  rcf_pkg::sts_t sts;

  rcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_tvalid && in_tready),
    .in_apply (in_tdata[0]),
    .sts      (sts),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  rcf_datapath #(.NUM_BODIES(NUM_BODIES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
